/* rtl/assert_macros.svh */
// Assertion helpers included by sfcd_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

/* rtl/sfcd_pkg.sv */
package sfcd_pkg;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int RESULT_CAP = 64;

	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_SYNC_THIRD  = 2'd2;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [7:0] SYNC_THIRD_RST  = 8'hCC;

	typedef enum logic [1:0] {
		ST_WORD = 2'd0,
		ST_CRC  = 2'd1,
		ST_LONG = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_SYNC3,
		PH_ADDR,
		PH_FUNC,
		PH_COUNT,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI,
		PH_EMIT_RD,
		PH_EMIT_WR
	} phase_t;

	typedef struct packed {
		logic    crc_init;
		logic    crc_feed;
		logic    cap_addr;
		logic    cap_func;
		logic    cap_count;
		logic    data_take;
		logic    cap_crc_lo;
		logic    emit_clear;
		logic    emit_read;
		logic    emit_push;
		logic    err_push;
		status_t err_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_first;
		logic is_second;
		logic is_third;
		logic count_long;
		logic count_zero;
		logic data_done;
		logic crc_match;
		logic words_zero;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

	// Reflected CRC-16, one byte folded in bit by bit.
	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/sfcd_in_if.sv */
interface sfcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/sfcd_out_if.sv */
interface sfcd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] reg_word;
	logic [5:0]  word_index;
	logic        last;
	logic [1:0]  status;
	logic [7:0]  device_address;
	logic [7:0]  function_code;

	modport source (output valid, output reg_word, output word_index, output last,
		output status, output device_address, output function_code, input ready);
	modport sink (input valid, input reg_word, input word_index, input last,
		input status, input device_address, input function_code, output ready);
endinterface

/* rtl/sfcd_datapath.sv */
module sfcd_datapath import sfcd_pkg::*; #(
	parameter int MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic [7:0]  rx_byte,
	input  ctl_cmd_t    cmd,
	output dp_stat_t    stat,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [15:0] reg_word,
	output logic [5:0]  word_index,
	output logic        last,
	output logic [1:0]  status,
	output logic [7:0]  device_address,
	output logic [7:0]  function_code
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CAP = (MAX_WORDS < RESULT_CAP) ? MAX_WORDS : RESULT_CAP;
	localparam logic [8:0] LONG_LIMIT = 9'(2 * MAX_WORDS);

	logic [7:0]  sync_first_q, sync_second_q, sync_third_q;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic [7:0]  addr_q, func_q, count_q, high_q, crc_lo_q;
	logic [7:0]  taken_q;
	logic [6:0]  emit_idx_q;
	logic [6:0]  half;
	logic [6:0]  words;
	logic [15:0] mem [MAX_WORDS];
	logic [15:0] rd_word_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic [5:0]  index_q;
	logic        last_q;
	status_t     status_q;
	logic [7:0]  dev_q, fn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			sync_third_q  <= SYNC_THIRD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SYNC_FIRST:  sync_first_q  <= wr_data;
				CFG_SYNC_SECOND: sync_second_q <= wr_data;
				CFG_SYNC_THIRD:  sync_third_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign crc_next = crc_feed(cmd.crc_init ? CRC_SEED : crc_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_SEED;
			taken_q    <= 8'd0;
			emit_idx_q <= 7'd0;
		end else begin
			if (cmd.crc_init || cmd.crc_feed) begin
				crc_q <= crc_next;
			end
			if (cmd.cap_count) begin
				taken_q <= 8'd0;
			end else if (cmd.data_take) begin
				taken_q <= stat.data_done ? 8'd0 : taken_q + 8'd1;
			end
			if (cmd.emit_clear) begin
				emit_idx_q <= 7'd0;
			end else if (cmd.emit_push) begin
				emit_idx_q <= emit_idx_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_addr) begin
			addr_q <= rx_byte;
		end
		if (cmd.cap_func) begin
			func_q <= rx_byte;
		end
		if (cmd.cap_count) begin
			count_q <= rx_byte;
		end
		if (cmd.cap_crc_lo) begin
			crc_lo_q <= rx_byte;
		end
		if (cmd.data_take && !taken_q[0]) begin
			high_q <= rx_byte;
		end
	end

	// Word store: written on the second byte of each pair, read one word per request.
	always_ff @(posedge clk) begin
		if (cmd.data_take && taken_q[0]) begin
			mem[taken_q[AW:1]] <= {high_q, rx_byte};
		end
		if (cmd.emit_read) begin
			rd_word_q <= mem[emit_idx_q[AW-1:0]];
		end
	end

	assign half  = count_q[7:1];
	assign words = (half > 7'(CAP)) ? 7'(CAP) : half;

	always_comb begin
		stat.is_first   = (rx_byte == sync_first_q);
		stat.is_second  = (rx_byte == sync_second_q);
		stat.is_third   = (rx_byte == sync_third_q);
		stat.count_long = ({1'b0, rx_byte} > LONG_LIMIT);
		stat.count_zero = (rx_byte == 8'd0);
		stat.data_done  = (({1'b0, taken_q} + 9'd1) >= {1'b0, count_q});
		stat.crc_match  = ({rx_byte, crc_lo_q} == crc_q);
		stat.words_zero = (words == 7'd0);
		stat.emit_last  = ((emit_idx_q + 7'd1) == words);
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.err_push || cmd.emit_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_push) begin
			word_q   <= 16'd0;
			index_q  <= 6'd0;
			last_q   <= 1'b1;
			status_q <= cmd.err_status;
			dev_q    <= addr_q;
			fn_q     <= func_q;
		end else if (cmd.emit_push) begin
			word_q   <= rd_word_q;
			index_q  <= emit_idx_q[5:0];
			last_q   <= stat.emit_last;
			status_q <= ST_WORD;
			dev_q    <= addr_q;
			fn_q     <= func_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reg_word       = word_q;
	assign word_index     = index_q;
	assign last           = last_q;
	assign status         = status_q;
	assign device_address = dev_q;
	assign function_code  = fn_q;

endmodule

/* rtl/sfcd_ctrl.sv */
`include "assert_macros.svh"

module sfcd_ctrl import sfcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	phase_t state_q, state_d;
	logic   in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_SYNC1;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_SYNC1: begin
				if (in_fire && stat.is_first) state_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (in_fire) begin
					if (stat.is_second) state_d = PH_SYNC3;
					else if (stat.is_first) state_d = PH_SYNC2;
					else state_d = PH_SYNC1;
				end
			end
			PH_SYNC3: begin
				if (in_fire) begin
					if (stat.is_third) state_d = PH_ADDR;
					else if (stat.is_first) state_d = PH_SYNC2;
					else state_d = PH_SYNC1;
				end
			end
			PH_ADDR: begin
				if (in_fire) state_d = PH_FUNC;
			end
			PH_FUNC: begin
				if (in_fire) state_d = PH_COUNT;
			end
			PH_COUNT: begin
				if (in_fire) begin
					if (stat.count_long) state_d = PH_SYNC1;
					else if (stat.count_zero) state_d = PH_CRC_LO;
					else state_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (in_fire && stat.data_done) state_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if (in_fire) state_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				if (in_fire) begin
					if (!stat.crc_match || stat.words_zero) state_d = PH_SYNC1;
					else state_d = PH_EMIT_RD;
				end
			end
			PH_EMIT_RD: begin
				state_d = PH_EMIT_WR;
			end
			PH_EMIT_WR: begin
				if (stat.out_free) begin
					state_d = stat.emit_last ? PH_SYNC1 : PH_EMIT_RD;
				end
			end
			default: state_d = PH_SYNC1;
		endcase
	end

	// Bytes that may raise a result wait until the output register can take it.
	always_comb begin
		in_ready = 1'b0;
		unique case (state_q) inside
			PH_SYNC1, PH_SYNC2, PH_SYNC3, PH_ADDR, PH_FUNC, PH_DATA, PH_CRC_LO: begin
				in_ready = 1'b1;
			end
			PH_COUNT, PH_CRC_HI: begin
				in_ready = stat.out_free;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.err_status = ST_CRC;
		unique case (state_q)
			PH_ADDR: begin
				cmd.crc_init = in_fire;
				cmd.cap_addr = in_fire;
			end
			PH_FUNC: begin
				cmd.crc_feed = in_fire;
				cmd.cap_func = in_fire;
			end
			PH_COUNT: begin
				cmd.crc_feed   = in_fire;
				cmd.cap_count  = in_fire;
				cmd.err_push   = in_fire && stat.count_long;
				cmd.err_status = ST_LONG;
			end
			PH_DATA: begin
				cmd.crc_feed  = in_fire;
				cmd.data_take = in_fire;
			end
			PH_CRC_LO: begin
				cmd.cap_crc_lo = in_fire;
			end
			PH_CRC_HI: begin
				cmd.err_push   = in_fire && !stat.crc_match;
				cmd.emit_clear = in_fire && stat.crc_match && !stat.words_zero;
			end
			PH_EMIT_RD: begin
				cmd.emit_read = 1'b1;
			end
			PH_EMIT_WR: begin
				cmd.emit_push = stat.out_free;
			end
			default: ;
		endcase
	end

	`ASSERT_NEVER(a_no_take_in_burst, clk, arst_n,
		(state_q == PH_EMIT_RD || state_q == PH_EMIT_WR) && in_ready,
		"byte accepted during word burst")
	`ASSERT_NEVER(a_single_push, clk, arst_n, cmd.err_push && cmd.emit_push,
		"two results pushed in one cycle")
	`ASSERT_CLK(a_push_needs_room, clk, arst_n,
		(cmd.err_push || cmd.emit_push) |-> stat.out_free,
		"result pushed into a full output register")
	`ASSERT_CLK(a_crc_fail_rehunt, clk, arst_n,
		(state_q == PH_CRC_HI && in_fire && !stat.crc_match) |=> (state_q == PH_SYNC1),
		"CRC mismatch did not return to the hunt")

endmodule

/* rtl/sync_frame_crc16_deframer_core.sv */
// Sync-framed CRC-16 deframer. Received bytes arrive one per request on in_ch; the block
// hunts for the three sync bytes (written through wr_en/wr_index/wr_data, indexes 0..2),
// then takes address, function, count N, N data bytes and a reflected CRC-16 (poly 0xA001,
// seed 0xFFFF) sent low byte first. While a frame is parsed one byte is taken per cycle;
// the count byte and the last CRC byte are held off only while the output register is
// still full. On a CRC match the N/2 big-endian words (at most 64) leave on out_ch,
// each first read from the MAX_WORDS x 16 word store into a register and then loaded
// into the output register, and no byte is taken during that burst. A CRC mismatch
// or a count above 2*MAX_WORDS gives a single error result with last set.
module sync_frame_crc16_deframer_core import sfcd_pkg::*; #(
	parameter int MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	sfcd_in_if.sink     in_ch,
	sfcd_out_if.source  out_ch
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	sfcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfcd_datapath #(
		.MAX_WORDS (MAX_WORDS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.rx_byte        (in_ch.rx_byte),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.reg_word       (out_ch.reg_word),
		.word_index     (out_ch.word_index),
		.last           (out_ch.last),
		.status         (out_ch.status),
		.device_address (out_ch.device_address),
		.function_code  (out_ch.function_code)
	);

endmodule

/* bench/sync_frame_crc16_deframer_core_test.sv */
`timescale 1ns / 1ps

module sync_frame_crc16_deframer_core_test;
	import sfcd_pkg::*;

	localparam int MAX_WORDS = 64;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 20;

	typedef struct {
		logic [15:0] reg_word;
		logic [5:0]  word_index;
		logic        last;
		status_t     status;
		logic [7:0]  device_address;
		logic [7:0]  function_code;
	} reg_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;

	sfcd_in_if  in_ch ();
	sfcd_out_if out_ch ();

	sync_frame_crc16_deframer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Parser state as the block should hold it.
	logic [7:0]  hdr_first, hdr_second, hdr_third;
	phase_t      frame_phase;
	logic [15:0] frame_crc;
	logic [7:0]  frame_len, bytes_in, high_hold, crc_lo;
	logic [7:0]  frame_addr, frame_func;
	logic [15:0] word_mem [MAX_WORDS];

	reg_result_t pending_words [$];
	logic [7:0]  frame_data [$];
	reg_result_t want_word;
	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned send_gap_pct;
	int unsigned ready_gap_pct;

	function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic reset_model();
		hdr_first = SYNC_FIRST_RST;
		hdr_second = SYNC_SECOND_RST;
		hdr_third = SYNC_THIRD_RST;
		frame_phase = PH_SYNC1;
		frame_crc = CRC_SEED;
		frame_len = '0;
		bytes_in = '0;
		high_hold = '0;
		crc_lo = '0;
		frame_addr = '0;
		frame_func = '0;
		for (int i = 0; i < MAX_WORDS; i++) begin
			word_mem[i] = '0;
		end
	endtask

	task automatic push_result(logic [15:0] w, logic [5:0] idx, logic fin, status_t st);
		reg_result_t r;
		r.reg_word = w;
		r.word_index = idx;
		r.last = fin;
		r.status = st;
		r.device_address = frame_addr;
		r.function_code = frame_func;
		pending_words.push_back(r);
	endtask

	task automatic parse_byte(logic [7:0] b);
		int unsigned words;
		logic [15:0] got;
		case (frame_phase)
			PH_SYNC1: begin
				if (b == hdr_first) begin
					frame_phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == hdr_second) begin
					frame_phase = PH_SYNC3;
				end else if (b == hdr_first) begin
					frame_phase = PH_SYNC2;
				end else begin
					frame_phase = PH_SYNC1;
				end
			end
			PH_SYNC3: begin
				if (b == hdr_third) begin
					frame_phase = PH_ADDR;
				end else if (b == hdr_first) begin
					frame_phase = PH_SYNC2;
				end else begin
					frame_phase = PH_SYNC1;
				end
			end
			PH_ADDR: begin
				frame_crc = crc16_fold(CRC_SEED, b);
				frame_addr = b;
				frame_phase = PH_FUNC;
			end
			PH_FUNC: begin
				frame_crc = crc16_fold(frame_crc, b);
				frame_func = b;
				frame_phase = PH_COUNT;
			end
			PH_COUNT: begin
				frame_crc = crc16_fold(frame_crc, b);
				frame_len = b;
				bytes_in = '0;
				if (int'(b) > 2 * MAX_WORDS) begin
					push_result(16'h0000, 6'd0, 1'b1, ST_LONG);
					frame_phase = PH_SYNC1;
					frame_crc = CRC_SEED;
				end else begin
					frame_phase = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
				end
			end
			PH_DATA: begin
				frame_crc = crc16_fold(frame_crc, b);
				if (!bytes_in[0]) begin
					high_hold = b;
				end else if (int'(bytes_in >> 1) < MAX_WORDS) begin
					word_mem[bytes_in >> 1] = {high_hold, b};
				end
				bytes_in = bytes_in + 8'd1;
				if (bytes_in >= frame_len) begin
					frame_phase = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_lo = b;
				frame_phase = PH_CRC_HI;
			end
			default: begin
				got = {b, crc_lo};
				if (got != frame_crc) begin
					push_result(16'h0000, 6'd0, 1'b1, ST_CRC);
				end else begin
					words = frame_len >> 1;
					if (words > MAX_WORDS) begin
						words = MAX_WORDS;
					end
					if (words > RESULT_CAP) begin
						words = RESULT_CAP;
					end
					for (int i = 0; i < words; i++) begin
						push_result(word_mem[i], 6'(i), (i + 1 == words), ST_WORD);
					end
				end
				frame_phase = PH_SYNC1;
				frame_crc = CRC_SEED;
			end
		endcase
	endtask

	// Holds the request until the block takes it; valid stays high on return so that
	// the next call can replace the byte without a dip.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.rx_byte = b;
		do @(posedge clk); while (!in_ch.ready);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_ch.valid = 1'b0;
		while (pending_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			CFG_SYNC_FIRST:  hdr_first = val;
			CFG_SYNC_SECOND: hdr_second = val;
			CFG_SYNC_THIRD:  hdr_third = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Brings the parser back to the hunt with a byte that matches no sync value.
	task automatic settle_to_hunt();
		logic [7:0] filler;
		filler = 8'h00;
		while (filler == hdr_first || filler == hdr_second || filler == hdr_third) begin
			filler = filler + 8'd1;
		end
		while (frame_phase != PH_SYNC1) begin
			send_byte(filler);
		end
	endtask

	task automatic send_header();
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_third);
	endtask

	// Sends address, function, count, then frame_data and the CRC unless the count
	// is too large for the store.
	task automatic send_body(logic [7:0] addr, logic [7:0] func, logic [7:0] len,
			logic [15:0] crc_flip);
		logic [15:0] crc;
		crc = crc16_fold(CRC_SEED, addr);
		crc = crc16_fold(crc, func);
		crc = crc16_fold(crc, len);
		send_byte(addr);
		send_byte(func);
		send_byte(len);
		if (int'(len) <= 2 * MAX_WORDS) begin
			for (int i = 0; i < len; i++) begin
				crc = crc16_fold(crc, frame_data[i]);
				send_byte(frame_data[i]);
			end
			crc = crc ^ crc_flip;
			send_byte(crc[7:0]);
			send_byte(crc[15:8]);
		end
	endtask

	task automatic fill_data(int unsigned len);
		frame_data.delete();
		for (int i = 0; i < len; i++) begin
			frame_data.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic test_directed_frames();
		// Repeated first bytes hold the hunt; a first byte in place of the third restarts it.
		send_byte(hdr_first);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_third);
		frame_data.delete();
		frame_data.push_back(8'hFF);
		frame_data.push_back(8'h00);
		send_body(8'h00, 8'hFF, 8'd2, 16'h0000);

		// A single data byte with a good CRC forms no word.
		send_header();
		frame_data.delete();
		frame_data.push_back(8'h5A);
		send_body(8'hFF, 8'h00, 8'd1, 16'h0000);

		send_header();
		frame_data.delete();
		send_body(8'h81, 8'h7E, 8'd255, 16'h0000);

		send_header();
		send_body(8'h3C, 8'hC3, 8'd0, 16'h8001);
	endtask

	task automatic test_largest_frame();
		send_header();
		fill_data(128);
		send_body(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd128, 16'h0000);
		send_header();
		frame_data.delete();
		send_body(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd129, 16'h0000);
	endtask

	task automatic test_random_traffic(int unsigned n);
		int unsigned stop_at;
		int unsigned r;
		int unsigned len;
		logic [15:0] flip;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			settle_to_hunt();
			if ($urandom_range(24) == 0) begin
				wait_drain();
			end
			r = $urandom_range(99);
			if (r < 8) begin
				repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
			end else if (r < 18) begin
				send_byte(hdr_first);
				repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				if (r < 78) begin
					len = $urandom_range(12, 0);
				end else if (r < 86) begin
					len = $urandom_range(40, 13);
				end else if (r < 90) begin
					len = $urandom_range(127, 41);
				end else begin
					len = $urandom_range(255, 129);
				end
				fill_data((len <= 2 * MAX_WORDS) ? len : 0);
				flip = ($urandom_range(9) == 0) ? 16'(1 << $urandom_range(15)) : 16'h0000;
				send_header();
				send_body(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len), flip);
			end
		end
		settle_to_hunt();
	endtask

	task automatic test_sync_bytes(logic [7:0] f, logic [7:0] s, logic [7:0] t,
			int unsigned n);
		wait_drain();
		cfg_write(CFG_SYNC_FIRST, f);
		cfg_write(CFG_SYNC_SECOND, s);
		cfg_write(CFG_SYNC_THIRD, t);
		cfg_write(CFG_UNUSED, ~f);
		test_random_traffic(n);
	endtask

	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= ready_gap_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result, expected none, got word %h status %0d",
					$time, out_ch.reg_word, out_ch.status);
				fail_count++;
			end else begin
				want_word = pending_words.pop_front();
				check_field("reg_word", want_word.reg_word, out_ch.reg_word);
				check_field("word_index", 16'(want_word.word_index), 16'(out_ch.word_index));
				check_field("last", 16'(want_word.last), 16'(out_ch.last));
				check_field("status", 16'(want_word.status), 16'(out_ch.status));
				check_field("device_address", 16'(want_word.device_address),
					16'(out_ch.device_address));
				check_field("function_code", 16'(want_word.function_code),
					16'(out_ch.function_code));
			end
		end
	end

	initial begin
		#2000000;
		$display("sync_frame_crc16_deframer_core: mismatch");
		$finish;
	end

	initial begin
		logic [7:0]  v;
		int unsigned waited;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = 8'h00;
		out_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_SYNC_FIRST;
		wr_data = 8'h00;
		send_gap_pct = 18;
		ready_gap_pct = 69;
		reset_model();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_random_traffic(14);

		send_gap_pct = 69;
		ready_gap_pct = 18;
		test_sync_bytes(8'h00, 8'hFF, 8'h00, 14);

		send_gap_pct = 0;
		ready_gap_pct = 0;
		test_sync_bytes(8'hFF, 8'h00, 8'hFF, 6);
		test_largest_frame();
		// All three sync bytes equal.
		v = 8'($urandom_range(255));
		test_sync_bytes(v, v, v, 6);

		in_ch.valid = 1'b0;
		waited = 0;
		while (pending_words.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_words.size());
			fail_count += pending_words.size();
		end
		if (fail_count == 0) begin
			$display("sync_frame_crc16_deframer_core: match");
		end else begin
			$display("sync_frame_crc16_deframer_core: mismatch");
		end
		$finish;
	end

endmodule
